FILE: sv/ptc_pkg.sv
// ptc_pkg: types and constants shared by the traffic counter table
// no dependencies
package ptc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic [63:0] group_id;
        logic [31:0] packet_len;
        logic        is_egress;
    } in_word_t;

    typedef struct packed {
        logic [63:0] rx_byte_total;
        logic [63:0] tx_byte_total;
        logic [63:0] rx_packet_total;
        logic [63:0] tx_packet_total;
        logic        row_created;
        logic        row_evicted;
    } out_word_t;

    typedef struct packed {
        logic [63:0] rx_octets;
        logic [63:0] tx_octets;
        logic [63:0] rx_packets;
        logic [63:0] tx_packets;
    } row_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic select;
        logic update;
    } ptc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ptc_status_t;

endpackage

FILE: sv/ptc_ctrl.sv
// ptc_ctrl: sequencer for lookup, slot choice and row update
// depends on ptc_pkg
module ptc_ctrl import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ptc_status_t status,
    output ptc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SELECT = 5'b00100,
        ST_READ   = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) state_next = ST_SELECT;
            end
            ST_SELECT: begin
                cmd.select = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

endmodule

FILE: sv/ptc_datapath.sv
// ptc_datapath: key, stamp and counter memories, search and lru tracking
// depends on ptc_pkg
module ptc_datapath import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_word_t    s_data,
    input  ptc_cmd_t    cmd,
    output ptc_status_t status,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    logic [63:0] key_mem   [TABLE_ENTRIES];
    logic [31:0] stamp_mem [TABLE_ENTRIES];
    row_t        row_mem   [TABLE_ENTRIES];

    in_word_t    item_reg;
    logic [CNT_W-1:0] fill_reg, issue_reg;
    logic [31:0] clock_reg;
    logic        pend_reg, found_reg, m_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg, hit_idx_reg, best_idx_reg, slot_reg;
    logic [31:0] best_age_reg;
    logic        created_reg, evicted_reg;
    logic [63:0] key_q;
    logic [31:0] stamp_q;
    row_t        row_q, row_new;
    out_word_t   out_reg;

    logic             issue_ok, table_full;
    logic [IDX_W-1:0] rd_addr, sel_slot;
    logic [31:0]      age;
    logic [63:0]      len_ext;

    assign table_full = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign issue_ok = cmd.scan && (issue_reg < fill_reg) && !found_reg;
    assign rd_addr = issue_reg[IDX_W-1:0];
    assign age = clock_reg - stamp_q;
    assign len_ext = {32'b0, item_reg.packet_len};
    assign sel_slot = found_reg ? hit_idx_reg :
                      (table_full ? best_idx_reg : fill_reg[IDX_W-1:0]);

    assign status.scan_done = found_reg || (!pend_reg && (issue_reg >= fill_reg));
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        row_new = created_reg ? '0 : row_q;
        if (item_reg.is_egress) begin
            row_new.tx_octets = row_new.tx_octets + len_ext;
            row_new.tx_packets = row_new.tx_packets + 64'd1;
        end else begin
            row_new.rx_octets = row_new.rx_octets + len_ext;
            row_new.rx_packets = row_new.rx_packets + 64'd1;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        key_q <= key_mem[rd_addr];
        stamp_q <= stamp_mem[rd_addr];
        row_q <= row_mem[slot_reg];
        if (cmd.select && !found_reg) key_mem[sel_slot] <= item_reg.group_id;
        if (cmd.update) begin
            row_mem[slot_reg] <= row_new;
            stamp_mem[slot_reg] <= clock_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        cmp_idx_reg <= rd_addr;
        if (pend_reg && !found_reg) begin
            if (key_q == item_reg.group_id) hit_idx_reg <= cmp_idx_reg;
            if (cmp_idx_reg == '0 || age > best_age_reg) begin
                best_age_reg <= age;
                best_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.select) begin
            slot_reg <= sel_slot;
            created_reg <= !found_reg;
            evicted_reg <= !found_reg && table_full;
        end
        if (cmd.update) begin
            out_reg.rx_byte_total <= row_new.rx_octets;
            out_reg.tx_byte_total <= row_new.tx_octets;
            out_reg.rx_packet_total <= row_new.rx_packets;
            out_reg.tx_packet_total <= row_new.tx_packets;
            out_reg.row_created <= created_reg;
            out_reg.row_evicted <= evicted_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            issue_reg <= '0;
            clock_reg <= '0;
            pend_reg <= 1'b0;
            found_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                issue_reg <= '0;
                pend_reg <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                issue_reg <= issue_reg + CNT_W'(issue_ok);
                pend_reg <= issue_ok;
                if (pend_reg && !found_reg && key_q == item_reg.group_id)
                    found_reg <= 1'b1;
            end
            if (cmd.select && !found_reg && !table_full) fill_reg <= fill_reg + CNT_W'(1);
            if (cmd.update) clock_reg <= clock_reg + 32'd1;
            if (cmd.update) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");
    a_evict_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.select && !found_reg && !table_full |=> !evicted_reg)
        else $error("eviction while a slot was free");
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.select && found_reg |-> hit_idx_reg < fill_reg[IDX_W-1:0] || table_full)
        else $error("hit outside filled slots");
    a_update_frees_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid_reg)
        else $error("result word lost");

endmodule

FILE: sv/per_key_traffic_counter_lru.sv
// per_key_traffic_counter_lru: top level of the per-key traffic counter table
// depends on ptc_pkg, ptc_ctrl, ptc_datapath
//
// One packet event is taken at a time. The key search reads one slot per cycle
// from the key memory, over the filled slots only (slots fill from zero and are
// never freed, so a fill count marks the valid ones); the same pass tracks the
// oldest stamp for replacement. A result word still waiting on m_ready holds
// the next update back. No clearing pass is needed after reset.
module per_key_traffic_counter_lru import ptc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    ptc_cmd_t    cmd;
    ptc_status_t status;

    ptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ptc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: dv/per_key_traffic_counter_lru_test.sv
// per_key_traffic_counter_lru_test: self-checking bench for the per-key traffic counter table
// depends on ptc_pkg and per_key_traffic_counter_lru; runs directed rows, then random traffic
// through table fill and lru replacement, each result checked against given totals or a local row predictor
module per_key_traffic_counter_lru_test;
    import ptc_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    per_key_traffic_counter_lru dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t totals;
    } stim_row_t;

    // table image
    logic [63:0] row_key    [TABLE_ENTRIES];
    bit          row_used   [TABLE_ENTRIES];
    logic [63:0] row_rxb    [TABLE_ENTRIES];
    logic [63:0] row_txb    [TABLE_ENTRIES];
    logic [63:0] row_rxp    [TABLE_ENTRIES];
    logic [63:0] row_txp    [TABLE_ENTRIES];
    logic [31:0] row_stamp  [TABLE_ENTRIES];
    logic [31:0] touch_count;
    int          rows_filled;

    out_word_t   pending_totals[$];
    logic [63:0] hot_keys[$];
    logic [63:0] seen_keys[$];
    stim_row_t   directed_rows[$];
    int          mismatches;
    bit          calm;
    bit          cur_typed;
    out_word_t   cur_totals;

    function automatic out_word_t account_packet(in_word_t w);
        int        slot;
        logic [31:0] best_age;
        logic [31:0] age;
        out_word_t r;
        r = '0;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && row_used[i] && row_key[i] == w.group_id) slot = i;
        if (slot < 0) begin
            r.row_created = 1'b1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && !row_used[i]) slot = i;
            if (slot < 0) begin
                r.row_evicted = 1'b1;
                slot = 0;
                best_age = touch_count - row_stamp[0];
                for (int i = 1; i < TABLE_ENTRIES; i++) begin
                    age = touch_count - row_stamp[i];
                    if (age > best_age) begin
                        slot = i;
                        best_age = age;
                    end
                end
            end else begin
                rows_filled++;
            end
            row_key[slot] = w.group_id;
            row_used[slot] = 1'b1;
            row_rxb[slot] = '0;
            row_txb[slot] = '0;
            row_rxp[slot] = '0;
            row_txp[slot] = '0;
        end
        row_stamp[slot] = touch_count;
        touch_count = touch_count + 32'd1;
        if (w.is_egress) begin
            row_txb[slot] = row_txb[slot] + {32'd0, w.packet_len};
            row_txp[slot] = row_txp[slot] + 64'd1;
        end else begin
            row_rxb[slot] = row_rxb[slot] + {32'd0, w.packet_len};
            row_rxp[slot] = row_rxp[slot] + 64'd1;
        end
        r.rx_byte_total = row_rxb[slot];
        r.tx_byte_total = row_txb[slot];
        r.rx_packet_total = row_rxp[slot];
        r.tx_packet_total = row_txp[slot];
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        out_word_t e;
        out_word_t p;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                p = account_packet(s_data);
                pending_totals.push_back(cur_typed ? cur_totals : p);
            end
            if (m_valid && m_ready) begin
                if (pending_totals.size() == 0) begin
                    note_mismatch("unexpected word", '0, m_data.rx_byte_total);
                end else begin
                    e = pending_totals.pop_front();
                    if (e.rx_byte_total !== m_data.rx_byte_total)
                        note_mismatch("rx_byte_total", e.rx_byte_total, m_data.rx_byte_total);
                    if (e.tx_byte_total !== m_data.tx_byte_total)
                        note_mismatch("tx_byte_total", e.tx_byte_total, m_data.tx_byte_total);
                    if (e.rx_packet_total !== m_data.rx_packet_total)
                        note_mismatch("rx_packet_total", e.rx_packet_total,
                                      m_data.rx_packet_total);
                    if (e.tx_packet_total !== m_data.tx_packet_total)
                        note_mismatch("tx_packet_total", e.tx_packet_total,
                                      m_data.tx_packet_total);
                    if (e.row_created !== m_data.row_created)
                        note_mismatch("row_created", e.row_created, m_data.row_created);
                    if (e.row_evicted !== m_data.row_evicted)
                        note_mismatch("row_evicted", e.row_evicted, m_data.row_evicted);
                end
            end
        end
    end

    always @(negedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);

    task automatic send_word(in_word_t w, bit typed, out_word_t totals);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        cur_typed = typed;
        cur_totals = totals;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    function automatic in_word_t make_word(logic [63:0] key);
        in_word_t w;
        int pick;
        pick = $urandom_range(7);
        w.group_id = key;
        w.packet_len = (pick < 2) ? $urandom_range(1500) :
                       (pick == 2) ? 32'hffff_ffff : $urandom;
        w.is_egress = $urandom_range(1);
        return w;
    endfunction

    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        seen_keys.push_back(k);
        return k;
    endfunction

    task automatic send_plain(logic [63:0] key);
        send_word(make_word(key), 1'b0, '0);
    endtask

    function automatic stim_row_t row(logic [63:0] key, logic [31:0] len, bit egress, bit typed,
                                      logic [63:0] rxb, logic [63:0] txb,
                                      logic [63:0] rxp, logic [63:0] txp, bit cr);
        stim_row_t r;
        r.word = '{group_id: key, packet_len: len, is_egress: egress};
        r.typed = typed;
        r.totals = '{rx_byte_total: rxb, tx_byte_total: txb, rx_packet_total: rxp,
                     tx_packet_total: txp, row_created: cr, row_evicted: 1'b0};
        return r;
    endfunction

    initial begin
        int pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        calm = 1'b0;
        cur_typed = 1'b0;
        cur_totals = '0;
        mismatches = 0;
        touch_count = '0;
        rows_filled = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            row_used[i] = 1'b0;
            row_key[i] = '0;
            row_stamp[i] = '0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        directed_rows.push_back(row(64'd0, 32'hffff_ffff, 1'b0, 1'b1,
                                    64'hffff_ffff, 0, 1, 0, 1'b1));
        directed_rows.push_back(row(64'd0, 32'hffff_ffff, 1'b0, 1'b1,
                                    64'h1_ffff_fffe, 0, 2, 0, 1'b0));
        directed_rows.push_back(row(64'd0, 32'd0, 1'b1, 1'b1,
                                    64'h1_ffff_fffe, 0, 2, 1, 1'b0));
        directed_rows.push_back(row('1, 32'd0, 1'b1, 1'b1, 0, 0, 0, 1, 1'b1));
        directed_rows.push_back(row('1, 32'hffff_ffff, 1'b1, 1'b1,
                                    0, 64'hffff_ffff, 0, 2, 1'b0));
        directed_rows.push_back(row(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, 1'b1,
                                    64'h8000_0000, 0, 1, 0, 1'b1));
        directed_rows.push_back(row(64'h1, 32'd1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0));
        directed_rows.push_back(row(64'h5555_aaaa_5555_aaaa, 32'h5555_aaaa, 1'b1, 1'b0,
                                    0, 0, 0, 0, 1'b0));
        directed_rows.push_back(row(64'haaaa_5555_aaaa_5555, 32'haaaa_5555, 1'b0, 1'b0,
                                    0, 0, 0, 0, 1'b0));
        directed_rows.push_back(row(64'h1, 32'd64, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0));
        directed_rows.push_back(row(64'd0, 32'd1, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0));
        directed_rows.push_back(row('1, 32'd1, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0));
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].totals);

        hot_keys = '{64'd0, '1, 64'h1, 64'h8000_0000_0000_0000};
        for (int i = 0; i < 12; i++) hot_keys.push_back(fresh_key());

        // small working set, cheap lookups
        for (int i = 0; i < 500; i++) begin
            calm = (i >= 150 && i < 250);
            send_plain(hot_keys[$urandom_range(hot_keys.size() - 1)]);
        end
        calm = 1'b0;

        // hold off until the table has answered everything
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_totals.size() == 0);

        // fill the table
        while (rows_filled < TABLE_ENTRIES) begin
            if ($urandom_range(4) == 0)
                send_plain(hot_keys[$urandom_range(hot_keys.size() - 1)]);
            else
                send_plain(fresh_key());
        end

        // full table, lru replacement
        for (int i = 0; i < 220; i++) begin
            pick = $urandom_range(9);
            if (pick < 5)
                send_plain(fresh_key());
            else if (pick < 8)
                send_plain(hot_keys[$urandom_range(hot_keys.size() - 1)]);
            else
                send_plain(seen_keys[$urandom_range(seen_keys.size() - 1)]);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_totals.size() == 0);
        repeat (1100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[per_key_traffic_counter_lru] OK");
        end else begin
            $display("[per_key_traffic_counter_lru] ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("[per_key_traffic_counter_lru] ERROR");
        $finish;
    end

endmodule

FILE: per_key_traffic_counter_lru.f
sv/ptc_pkg.sv
sv/ptc_ctrl.sv
sv/ptc_datapath.sv
sv/per_key_traffic_counter_lru.sv
dv/per_key_traffic_counter_lru_test.sv
